[hw/rtl/mxt_pkg.sv]
package mxt_pkg;

   localparam int FUNC_W = 2;
   localparam int OPND_W = 30;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [OPND_W-1:0]   operand;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_APPLY,
      ST_QUERY,
      ST_RESULT
   } st_type;

endpackage

[hw/rtl/mxt_ram.sv]
module mxt_ram #(
   parameter int WIDTH = 35,
   parameter int DEPTH = 8192,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[hw/rtl/mxt_front.sv]
module mxt_front import mxt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [OPND_W-1:0] req_operand,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output cmd_type           cmd
);

   cmd_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               keep;
   logic               push;
   logic               pop;

   // unknown function codes are taken and dropped
   always_comb begin
      case (req_func)
         OP_INSERT, OP_REMOVE, OP_QUERY: keep = 1'b1;
         default:                        keep = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != QCNT_W'(QDEPTH));
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{op: op_type'(req_func), operand: req_operand};
      end
   end

endmodule

[hw/rtl/mxt_back.sv]
module mxt_back import mxt_pkg::*; #(
   parameter int VALUE_BITS = 30,
   parameter int NODE_COUNT = 8192,
   parameter int COUNT_BITS = 9,
   localparam int IDX_W  = $clog2(NODE_COUNT),
   localparam int NODE_W = COUNT_BITS + 2 * IDX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cmd_type           cmd,
   output logic              ram_wr_en,
   output logic [IDX_W-1:0]  ram_wr_addr,
   output logic [NODE_W-1:0] ram_wr_data,
   output logic              ram_rd_en,
   output logic [IDX_W-1:0]  ram_rd_addr_a,
   output logic [IDX_W-1:0]  ram_rd_addr_b,
   input  logic [NODE_W-1:0] ram_rd_data_a,
   input  logic [NODE_W-1:0] ram_rd_data_b,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OPND_W-1:0] rsp_max_xor
);

   localparam int NF_W  = $clog2(NODE_COUNT + 1);
   localparam int REM_W = $clog2(VALUE_BITS + 1);

   typedef struct packed {
      logic [COUNT_BITS-1:0] cnt;
      logic [IDX_W-1:0]      kid1;
      logic [IDX_W-1:0]      kid0;
   } node_type;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   st_type                 state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in;
   logic [VALUE_BITS-1:0]  sh_ff, sh_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic                   at_root_ff, at_root_in;
   logic                   fresh_ff, fresh_in;
   logic                   dead_ff, dead_in;
   logic [VALUE_BITS-1:0]  best_ff, best_in;
   logic [IDX_W-1:0]       l0_ff, l0_in;
   logic [IDX_W-1:0]       l1_ff, l1_in;
   node_type               root_ff, root_in;
   logic [NF_W-1:0]        free_ff, free_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OPND_W-1:0]      rsp_data_ff, rsp_data_in;

   node_type               rd_a, rd_b, node, upd, nxt;
   logic [VALUE_BITS-1:0]  cmd_val;
   logic                   bit_now;
   logic [IDX_W-1:0]       kid;
   logic                   alloc;
   logic [IDX_W-1:0]       kid_use;
   logic [REM_W-1:0]       need;
   logic                   fit;
   logic                   p0, p1, p_opp, p_same;
   logic [VALUE_BITS-1:0]  best_new;

   assign rd_a     = node_type'(ram_rd_data_a);
   assign rd_b     = node_type'(ram_rd_data_b);
   assign cmd_val  = VALUE_BITS'(cmd.operand);
   assign node     = at_root_ff ? root_ff : (fresh_ff ? node_type'('0) : rd_a);
   assign bit_now  = sh_ff[VALUE_BITS-1];
   assign kid      = bit_now ? node.kid1 : node.kid0;
   assign alloc    = (op_ff == OP_INSERT) && (kid == '0);
   assign kid_use  = alloc ? free_ff[IDX_W-1:0] : kid;
   assign need     = (kid == '0) ? rem_ff : '0;
   assign fit      = ({1'b0, free_ff} + (NF_W + 1)'(need)) <= (NF_W + 1)'(NODE_COUNT);

   // query: presence of both children of the current node
   assign p0       = (l0_ff != '0) && (rd_a.cnt != '0);
   assign p1       = (l1_ff != '0) && (rd_b.cnt != '0);
   assign p_opp    = bit_now ? p0 : p1;
   assign p_same   = bit_now ? p1 : p0;
   assign nxt      = (p_opp ^ bit_now) ? rd_b : rd_a;
   assign best_new = (best_ff << 1) | VALUE_BITS'(!dead_ff && p_opp);

   always_comb begin
      upd = node;
      if (op_ff == OP_INSERT) begin
         upd.cnt = (node.cnt == CNT_MAX) ? node.cnt : node.cnt + COUNT_BITS'(1);
         if (alloc && rem_ff != '0) begin
            if (bit_now) begin
               upd.kid1 = kid_use;
            end else begin
               upd.kid0 = kid_use;
            end
         end
      end else begin
         upd.cnt = node.cnt - COUNT_BITS'(1);
      end
   end

   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      sh_in         = sh_ff;
      rem_in        = rem_ff;
      cur_in        = cur_ff;
      at_root_in    = at_root_ff;
      fresh_in      = fresh_ff;
      dead_in       = dead_ff;
      best_in       = best_ff;
      l0_in         = l0_ff;
      l1_in         = l1_ff;
      root_in       = root_ff;
      free_in       = free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cur_ff;
      ram_wr_data   = NODE_W'(upd);
      ram_rd_en     = 1'b0;
      ram_rd_addr_a = kid;
      ram_rd_addr_b = '0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               op_in      = cmd.op;
               val_in     = cmd_val;
               sh_in      = cmd_val;
               rem_in     = REM_W'(VALUE_BITS);
               at_root_in = 1'b1;
               fresh_in   = 1'b0;
               dead_in    = 1'b0;
               best_in    = '0;
               if (cmd.op == OP_QUERY) begin
                  ram_rd_en     = 1'b1;
                  ram_rd_addr_a = root_ff.kid0;
                  ram_rd_addr_b = root_ff.kid1;
                  l0_in         = root_ff.kid0;
                  l1_in         = root_ff.kid1;
                  state_in      = ST_QUERY;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         // first walk: find where the path ends and whether the word may proceed
         ST_CHECK: begin
            if (op_ff == OP_INSERT) begin
               if (rem_ff == '0 || kid == '0) begin
                  state_in = fit ? ST_APPLY : ST_IDLE;
               end
            end else if (node.cnt == '0 || (rem_ff != '0 && kid == '0)) begin
               state_in = ST_IDLE;
            end else if (rem_ff == '0) begin
               state_in = ST_APPLY;
            end
            if (state_in == ST_CHECK) begin
               ram_rd_en  = 1'b1;
               cur_in     = kid;
               at_root_in = 1'b0;
               fresh_in   = 1'b0;
               rem_in     = rem_ff - REM_W'(1);
               sh_in      = sh_ff << 1;
            end else if (state_in == ST_APPLY) begin
               rem_in     = REM_W'(VALUE_BITS);
               sh_in      = val_ff;
               at_root_in = 1'b1;
               fresh_in   = 1'b0;
            end
         end

         // second walk: update every node on the path
         ST_APPLY: begin
            if (at_root_ff) begin
               root_in = upd;
            end else begin
               ram_wr_en = 1'b1;
            end
            if (rem_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ram_rd_en     = !alloc;
               ram_rd_addr_a = kid;
               cur_in        = kid_use;
               at_root_in    = 1'b0;
               fresh_in      = alloc;
               rem_in        = rem_ff - REM_W'(1);
               sh_in         = sh_ff << 1;
               if (alloc) begin
                  free_in = free_ff + NF_W'(1);
               end
            end
         end

         ST_QUERY: begin
            dead_in       = dead_ff || (!p_opp && !p_same);
            ram_rd_en     = !dead_in;
            ram_rd_addr_a = nxt.kid0;
            ram_rd_addr_b = nxt.kid1;
            l0_in         = nxt.kid0;
            l1_in         = nxt.kid1;
            sh_in         = sh_ff << 1;
            rem_in        = rem_ff - REM_W'(1);
            if (rem_ff == REM_W'(1)) begin
               best_in  = (best_new > val_ff) ? best_new : val_ff;
               state_in = ST_RESULT;
            end else begin
               best_in = best_new;
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OPND_W'(best_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         root_ff      <= '0;
         free_ff      <= NF_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      sh_ff       <= sh_in;
      rem_ff      <= rem_in;
      cur_ff      <= cur_in;
      at_root_ff  <= at_root_in;
      fresh_ff    <= fresh_in;
      dead_ff     <= dead_in;
      best_ff     <= best_in;
      l0_ff       <= l0_in;
      l1_ff       <= l1_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_xor = rsp_data_ff;

endmodule

[hw/rtl/multiset_max_xor_trie.sv]
// Multiset of values kept in a binary trie with per-node occurrence counts.
// Request channel (req_valid/req_ready): req_func selects insert, remove or
// max-xor query; req_operand is the value. An unknown function code is
// taken and dropped. Only a query returns a word on the response channel
// (rsp_valid/rsp_ready): rsp_max_xor, the largest operand xor member, zero
// always counted as a member.
// A two-entry queue takes requests while the walk engine is busy; the
// engine works on one word at a time and walks one trie level per cycle,
// reading node memory with a registered read.
// Insert and remove: a checking walk, then an updating walk; these set the
// sustained rate of the block.
// Reset empties the trie at once: the root lives in flip-flops and the node
// allocator restarts, so no memory clearing pass is needed.
// A response waiting on rsp_ready holds the engine only at the end of the
// next query; the queue keeps taking requests until it is full.
module multiset_max_xor_trie import mxt_pkg::*; #(
   parameter int VALUE_BITS = 30,
   parameter int NODE_COUNT = 8192,
   parameter int COUNT_BITS = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [OPND_W-1:0] req_operand,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [OPND_W-1:0] rsp_max_xor
);

   localparam int IDX_W  = $clog2(NODE_COUNT);
   localparam int NODE_W = COUNT_BITS + 2 * IDX_W;

   cmd_type           cmd;
   logic              cmd_valid;
   logic              cmd_ready;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [NODE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr_a;
   logic [IDX_W-1:0]  ram_rd_addr_b;
   logic [NODE_W-1:0] ram_rd_data_a;
   logic [NODE_W-1:0] ram_rd_data_b;

   mxt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_operand (req_operand),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   mxt_back #(
      .VALUE_BITS (VALUE_BITS),
      .NODE_COUNT (NODE_COUNT),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr_a (ram_rd_addr_a),
      .ram_rd_addr_b (ram_rd_addr_b),
      .ram_rd_data_a (ram_rd_data_a),
      .ram_rd_data_b (ram_rd_data_b),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_max_xor   (rsp_max_xor)
   );

   mxt_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ram_rd_en),
      .rd_addr_a (ram_rd_addr_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_a (ram_rd_data_a),
      .rd_data_b (ram_rd_data_b)
   );

`ifndef ASSERT_OFF
   // the root is held in flip-flops, never in node memory
   a_wr_not_root: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> ram_wr_addr != '0)
      else $error("node memory write to root slot");

   // the updating walk writes a parent while reading its child
   a_wr_rd_apart: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr_a)
      else $error("node memory read and write collide");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && cmd_ready |=> !cmd_ready)
      else $error("engine took a word without starting a walk");
`endif

endmodule
